[src/scm_pkg.sv]
// shared types, constants and helpers for the swap-chain reference-count manager
// no dependencies
package scm_pkg;

  localparam int CONSUMERS = 8;
  localparam int REF_BITS  = 8;
  localparam int NBUF      = 3;

  localparam int CIDX_W = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
  localparam int CNT_W  = $clog2(CONSUMERS + 1);
  localparam int TOT_W  = REF_BITS + $clog2(CONSUMERS);

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  // operation codes
  localparam logic [2:0] OP_BEGIN   = 3'd0;
  localparam logic [2:0] OP_END     = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_CONNECT = 3'd3;
  localparam logic [2:0] OP_DROP    = 3'd4;

  // buffering modes held in buffer_count
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;
  localparam logic [1:0] MODE_TRIPLE = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [1:0] buffer;
    logic [2:0] client_slot;
  } op_item_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  chosen_buffer;
    logic [63:0] frame_number;
    logic [2:0]  granted_slot;
    logic [7:0]  notified_mask;
  } result_t;

  // per-slot command from the core
  typedef struct packed {
    logic       end_en;
    logic       rel_en;
    logic       drop_en;
    logic       grant;
    logic [1:0] buffer;
  } lane_cmd_t;

  // per-slot status back to the core
  typedef struct packed {
    logic                               active;
    logic                               not_sat;
    logic                               nz;
    logic [NBUF-1:0][REF_BITS-1:0]      refs;
  } lane_stat_t;

  // (x + n) mod 3 for small x, n
  function automatic logic [1:0] mod3_add(input logic [1:0] x, input logic [1:0] n);
    logic [2:0] s;
    s = {1'b0, x} + {1'b0, n};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return s[1:0];
  endfunction

endpackage

[src/scm_lane.sv]
// one consumer slot: active flag and its reference counts on each buffer
// depends on scm_pkg
module scm_lane (
  input  logic               clk,
  input  logic               rst,
  input  scm_pkg::lane_cmd_t cmd,
  output scm_pkg::lane_stat_t stat
);

  logic                                         active;
  logic [scm_pkg::NBUF-1:0][scm_pkg::REF_BITS-1:0] refs;
  logic [scm_pkg::REF_BITS-1:0]                 cur;
  logic                                         buf_ok;

  always_comb begin
    buf_ok = (int'(cmd.buffer) < scm_pkg::NBUF);
    cur    = buf_ok ? refs[cmd.buffer] : '0;
  end

  assign stat.active  = active;
  assign stat.not_sat = (cur != scm_pkg::REF_MAX);
  assign stat.nz      = (cur != '0);
  assign stat.refs    = refs;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      refs   <= '0;
    end else begin
      if (cmd.grant) begin
        active <= 1'b1;
      end
      if (cmd.drop_en) begin
        active <= 1'b0;
        refs   <= '0;
      end else if (buf_ok) begin
        if (cmd.end_en && active && cur != scm_pkg::REF_MAX) begin
          refs[cmd.buffer] <= cur + 1'b1;
        end else if (cmd.rel_en && cur != '0) begin
          refs[cmd.buffer] <= cur - 1'b1;
        end
      end
    end
  end

endmodule

[src/scm_core.sv]
// buffer choice, total counts, frame counter and result forming
// depends on scm_pkg; drives the per-slot lanes through lane_cmd_t
module scm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  scm_pkg::op_item_t   item,
  input  logic [1:0]          buffer_count,
  input  scm_pkg::lane_stat_t stat [scm_pkg::CONSUMERS],
  output scm_pkg::lane_cmd_t  cmd  [scm_pkg::CONSUMERS],
  output scm_pkg::result_t    res
);

  logic [1:0]                                   current_buffer;
  logic [1:0]                                   next_write;
  logic [63:0]                                  frame_counter;
  logic [scm_pkg::NBUF-1:0][scm_pkg::TOT_W-1:0] total_refs;
  logic [scm_pkg::NBUF-1:0][scm_pkg::TOT_W-1:0] total_refs_next;

  logic                          buf_valid, slot_valid;
  logic                          end_ok, rel_ok, drop_ok, conn_op;
  logic [scm_pkg::NBUF-1:0]      free_vec;
  logic [scm_pkg::CONSUMERS-1:0] active_vec, inc_vec;
  logic [scm_pkg::CNT_W-1:0]     inc_cnt;
  logic                          found;
  logic [scm_pkg::CIDX_W-1:0]    grant_idx;
  logic                          slot_nz;
  logic [scm_pkg::NBUF-1:0][scm_pkg::REF_BITS-1:0] slot_refs;
  logic [1:0]                    c0, c1, c2;

  always_comb begin
    buf_valid  = (int'(item.buffer) < scm_pkg::NBUF) && (item.buffer < buffer_count);
    slot_valid = (int'(item.client_slot) < scm_pkg::CONSUMERS);
    end_ok     = (item.operation == scm_pkg::OP_END) && buf_valid;
    rel_ok     = (item.operation == scm_pkg::OP_RELEASE) && buf_valid && slot_valid;
    drop_ok    = (item.operation == scm_pkg::OP_DROP) && slot_valid;
    conn_op    = (item.operation == scm_pkg::OP_CONNECT);

    for (int b = 0; b < scm_pkg::NBUF; b++) begin
      free_vec[b] = (2'(b) < buffer_count) && (2'(b) != current_buffer) &&
                    (total_refs[b] == '0);
    end

    // lowest free slot, lanes gathered into vectors
    found     = 1'b0;
    grant_idx = '0;
    slot_nz   = 1'b0;
    slot_refs = '0;
    for (int i = scm_pkg::CONSUMERS - 1; i >= 0; i--) begin
      active_vec[i] = stat[i].active;
      inc_vec[i]    = stat[i].active && stat[i].not_sat;
      if (!stat[i].active) begin
        found     = 1'b1;
        grant_idx = scm_pkg::CIDX_W'(i);
      end
      if (int'(item.client_slot) == i) begin
        slot_nz   = stat[i].nz;
        slot_refs = stat[i].refs;
      end
    end
    inc_cnt = scm_pkg::CNT_W'($countones(inc_vec));

    c0 = scm_pkg::mod3_add(next_write, 2'd0);
    c1 = scm_pkg::mod3_add(next_write, 2'd1);
    c2 = scm_pkg::mod3_add(next_write, 2'd2);
  end

  // lane commands
  always_comb begin
    for (int i = 0; i < scm_pkg::CONSUMERS; i++) begin
      cmd[i].end_en  = go && end_ok;
      cmd[i].rel_en  = go && rel_ok && (int'(item.client_slot) == i);
      cmd[i].drop_en = go && drop_ok && (int'(item.client_slot) == i);
      cmd[i].grant   = go && conn_op && found && (int'(grant_idx) == i);
      cmd[i].buffer  = item.buffer;
    end
  end

  // result word
  always_comb begin
    res = '0;
    case (item.operation)
      scm_pkg::OP_BEGIN: begin
        case (buffer_count)
          scm_pkg::MODE_SINGLE: begin
            res.ok = (total_refs[0] == '0);
          end
          scm_pkg::MODE_DOUBLE: begin
            if (free_vec[{1'b0, ~current_buffer[0]}]) begin
              res.ok            = 1'b1;
              res.chosen_buffer = {1'b0, ~current_buffer[0]};
            end
          end
          scm_pkg::MODE_TRIPLE: begin
            if (free_vec[c0]) begin
              res.ok            = 1'b1;
              res.chosen_buffer = c0;
            end else if (free_vec[c1]) begin
              res.ok            = 1'b1;
              res.chosen_buffer = c1;
            end else if (free_vec[c2]) begin
              res.ok            = 1'b1;
              res.chosen_buffer = c2;
            end
          end
          default: begin
            res.ok = 1'b0;
          end
        endcase
      end
      scm_pkg::OP_END: begin
        if (end_ok) begin
          res.ok            = 1'b1;
          res.chosen_buffer = item.buffer;
          res.frame_number  = frame_counter + 64'd1;
          res.notified_mask = 8'(active_vec);
        end
      end
      scm_pkg::OP_CONNECT: begin
        res.ok           = found;
        res.granted_slot = found ? 3'(grant_idx) : 3'd0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // totals follow the sum of the lane counts
  always_comb begin
    total_refs_next = total_refs;
    for (int b = 0; b < scm_pkg::NBUF; b++) begin
      if (end_ok && int'(item.buffer) == b) begin
        total_refs_next[b] = total_refs[b] + scm_pkg::TOT_W'(inc_cnt);
      end
      if (rel_ok && slot_nz && int'(item.buffer) == b && total_refs[b] != '0) begin
        total_refs_next[b] = total_refs[b] - 1'b1;
      end
      if (drop_ok) begin
        total_refs_next[b] = (total_refs[b] >= scm_pkg::TOT_W'(slot_refs[b])) ?
                             total_refs[b] - scm_pkg::TOT_W'(slot_refs[b]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_buffer <= '0;
      next_write     <= '0;
      frame_counter  <= '0;
      total_refs     <= '0;
    end else if (go) begin
      total_refs <= total_refs_next;
      if (end_ok) begin
        frame_counter  <= frame_counter + 64'd1;
        current_buffer <= item.buffer;
        if (buffer_count == scm_pkg::MODE_TRIPLE) begin
          next_write <= scm_pkg::mod3_add(item.buffer, 2'd1);
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_cur_follows_end: assert property (@(posedge clk) disable iff (rst)
    go && end_ok |=> current_buffer == $past(item.buffer))
    else $error("current buffer not updated by end");

  a_frame_only_on_end: assert property (@(posedge clk) disable iff (rst)
    !(go && end_ok) |=> $stable(frame_counter))
    else $error("frame counter moved without end");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(current_buffer) < scm_pkg::NBUF && int'(next_write) < scm_pkg::NBUF)
    else $error("buffer pointer out of range");

  a_begin_unreferenced: assert property (@(posedge clk) disable iff (rst)
    go && item.operation == scm_pkg::OP_BEGIN && res.ok |->
      total_refs[res.chosen_buffer] == '0)
    else $error("begin picked a referenced buffer");
`endif

endmodule

[src/swap_chain_refcount_manager_top.sv]
// top level of the swap-chain reference-count manager
// depends on scm_pkg, scm_lane and scm_core
//
// usage
//   op channel: op_valid / op_stall / op_word (operation, buffer, client_slot);
//     a word is taken on a rising edge with op_valid high and op_stall low
//   res channel: res_valid / res_stall / res_word, one result word per op word,
//     in order
//   cfg channel: cfg_valid / cfg_ready / cfg_data writes buffer_count;
//     cfg_ready is always high, write only while no op word is in flight
// throughput
//   an op word is held in the input register and is worked out in one
//   pass through the core into the result register; one word per cycle
//   sustained while res_stall does not hold a waiting result
// reset
//   rst (synchronous) empties both registers, clears all slots, reference
//   counts, the frame counter and both buffer pointers; buffer_count becomes 2
// stalls
//   while res_stall holds a waiting result, the input register holds its word
//   and op_stall rises only once that register is full
module swap_chain_refcount_manager_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_stall,
  input  scm_pkg::op_item_t op_word,
  output logic              res_valid,
  input  logic              res_stall,
  output scm_pkg::result_t  res_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  logic              s1_valid;
  scm_pkg::op_item_t s1_word;
  logic              adv;
  logic              go;
  logic [1:0]        buffer_count;
  scm_pkg::result_t  core_res;

  scm_pkg::lane_cmd_t  cmd  [scm_pkg::CONSUMERS];
  scm_pkg::lane_stat_t stat [scm_pkg::CONSUMERS];

  // input register moves on when the result register is empty or being taken
  assign adv       = !res_valid || !res_stall;
  assign go        = s1_valid && adv;
  assign op_stall  = s1_valid && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      res_valid    <= 1'b0;
      buffer_count <= scm_pkg::MODE_DOUBLE;
    end else begin
      if (!op_stall) begin
        s1_valid <= op_valid;
      end
      if (adv) begin
        res_valid <= s1_valid;
      end
      if (cfg_valid && cfg_ready) begin
        buffer_count <= cfg_data;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (op_valid && !op_stall) begin
      s1_word <= op_word;
    end
    if (go) begin
      res_word <= core_res;
    end
  end

  scm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .item         (s1_word),
    .buffer_count (buffer_count),
    .stat         (stat),
    .cmd          (cmd),
    .res          (core_res)
  );

  // one lane per consumer slot
  for (genvar i = 0; i < scm_pkg::CONSUMERS; i++) begin : g_lane
    scm_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd[i]),
      .stat (stat[i])
    );
  end

endmodule
